/* rtl/labeled_mean_sigma_rms_assert.svh */
// Assertion macros for the grouped statistics block.
// Used by the top level; relies on signals named clock and reset in scope.
`ifndef LABELED_MEAN_SIGMA_RMS_ASSERT_SVH
`define LABELED_MEAN_SIGMA_RMS_ASSERT_SVH

// Property checked on every clock edge outside reset
`define LMSR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Trigger in one cycle implies a property in the next cycle
`define LMSR_ASSERT_NEXT(lbl, trig, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

/* rtl/lmsr_pkg.sv */
// Shared constants and types for the grouped statistics block.
// No dependencies; imported by the top level.
package lmsr_pkg;

   // sizing of the block
   localparam int NUM_GROUPS  = 64;
   localparam int MAX_SAMPLES = 1048576;
   localparam int SAMPLE_BITS = 16;

   // field and store widths
   localparam int GRP_W   = 6;
   localparam int CNT_W   = 21;
   localparam int SUM_W   = 36;
   localparam int SQ_W    = 51;
   localparam int BATCH_W = 21;
   localparam int OUT_W   = 24;
   localparam int FRAC_W  = 8;
   localparam int SCALE_W = 16;
   localparam int SQR_W   = 2 * SAMPLE_BITS;

   // datapath widths
   localparam int PROD_W  = 72;                 // n*sumsq and sum^2
   localparam int NUM_W   = PROD_W + SCALE_W;   // dividend
   localparam int DEN_W   = 2 * CNT_W;          // divisor up to n^2
   localparam int CTR_W   = $clog2(NUM_W + 1);
   localparam int ROOT_W  = OUT_W + 1;
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int SREM_W  = ROOT_W + 1;
   localparam int SAT_SH  = 48;                 // quotient saturates at 2^48

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_USE_LABELS = CSR_IDX_W'(0);

   // one store entry
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [SUM_W-1:0] sum;
      logic [SQ_W-1:0]  sumsq;
   } lmsr_entry_type;

endpackage

/* rtl/lmsr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lmsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/labeled_mean_sigma_rms.sv */
// Grouped mean / standard deviation / RMS, top level.
// Depends on lmsr_pkg, lmsr_ram and labeled_mean_sigma_rms_assert.svh.
//
// Per-group count, sum and sum of squares live in one 64-entry RAM with
// registered read data. Each sample has its RAM read issued at
// acceptance, then the modify and write-back; no new sample is taken until
// the write-back is done. The store is valid-masked, so reset and the
// end-of-batch clear take effect at once with no clearing pass. On a sample
// with last set the block reports groups 0 up to the highest label seen,
// one at a time through a shared bit-serial multiplier (two products),
// a shift-subtract divider (three quotients) and a
// digit-by-digit square root (used twice). No sample is accepted during
// reporting.
`include "labeled_mean_sigma_rms_assert.svh"

module labeled_mean_sigma_rms
   import lmsr_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   // sample channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic [GRP_W-1:0]              req_label,
   input  logic                          req_last,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [GRP_W-1:0]              rsp_group,
   output logic [CNT_W-1:0]              rsp_count,
   output logic signed [OUT_W-1:0]       rsp_mean_value,
   output logic [OUT_W-1:0]              rsp_std_dev,
   output logic [OUT_W-1:0]              rsp_rms_value,
   output logic                          rsp_overflow,
   output logic                          rsp_last_of_run,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [CSR_DATA_W-1:0]         csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready
);

   typedef enum logic [3:0] {
      S_IDLE, S_ACC, S_EREAD, S_ELOAD, S_MUL1, S_MUL2,
      S_DIVM, S_DIVS, S_SQRS, S_DIVR, S_SQRR, S_OUT
   } state_type;

   state_type              state_ff, state_in;
   logic                   use_labels_ff, use_labels_in;
   logic [NUM_GROUPS-1:0]  valid_ff, valid_in;
   logic [GRP_W-1:0]       highest_ff, highest_in;
   logic [BATCH_W-1:0]     batch_ff, batch_in;
   logic                   ovf_ff, ovf_in;
   logic [GRP_W-1:0]       lab_ff, lab_in;
   logic signed [SAMPLE_BITS-1:0] smp_ff, smp_in;
   logic signed [SQR_W-1:0] sqr_ff, sqr_in;
   logic                   last_ff, last_in;
   logic                   acc_en_ff, acc_en_in;
   logic [GRP_W-1:0]       grp_ff, grp_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic                   neg_ff, neg_in;
   logic [SUM_W-1:0]       smag_ff, smag_in;
   logic [DEN_W-1:0]       nn_ff, nn_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [PROD_W-1:0]      mul_a_ff, mul_a_in;
   logic [SUM_W-1:0]       mul_b_ff, mul_b_in;
   logic [PROD_W-1:0]      macc_ff, macc_in;
   logic [NUM_W-1:0]       num_ff, num_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   logic [DEN_W-1:0]       rem_ff, rem_in;
   logic [NUM_W-1:0]       quo_ff, quo_in;
   logic [CTR_W-1:0]       ctr_ff, ctr_in;
   logic [RAD_W-1:0]       rad_ff, rad_in;
   logic [ROOT_W-1:0]      root_ff, root_in;
   logic [SREM_W-1:0]      srem_ff, srem_in;
   logic [OUT_W-1:0]       mean_ff, mean_in;
   logic [OUT_W-1:0]       sd_ff, sd_in;
   logic [OUT_W-1:0]       rms_ff, rms_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // step logic
   logic                   req_xact, rsp_xact, csr_wr;
   logic [GRP_W-1:0]       lab_sel;
   logic                   in_rng, batch_full;
   logic [GRP_W-1:0]       ent_idx;
   lmsr_entry_type         ram_rdata, ram_wdata, ent;
   logic                   ram_we;
   logic [GRP_W-1:0]       ram_raddr;
   logic [PROD_W-1:0]      macc_nx;
   logic [DEN_W:0]         rem_sh, rem_full;
   logic                   div_ge;
   logic [DEN_W-1:0]       rem_nx;
   logic [NUM_W-1:0]       quo_nx, quo_sat, mean_v, mean_neg;
   logic [SREM_W+1:0]      srem_sh, srem_trial, srem_full;
   logic                   sqrt_ge;
   logic [ROOT_W-1:0]      root_nx;
   logic [OUT_W-1:0]       root_sat, mean_res;
   logic                   step_done;

   assign req_xact = req_valid && req_ready;
   assign rsp_xact = rsp_valid_ff && rsp_ready;
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register port
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[CSR_ADDR_W-1:2])
         REG_USE_LABELS: csr_prdata = CSR_DATA_W'(use_labels_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // label routing and admission checks
   assign lab_sel    = use_labels_ff ? req_label : '0;
   assign in_rng     = {1'b0, lab_sel} < (GRP_W + 1)'(NUM_GROUPS);
   assign batch_full = batch_ff >= BATCH_W'(MAX_SAMPLES);

   // state store
   assign ram_raddr = (state_ff == S_IDLE) ? lab_sel : grp_ff;
   assign ent_idx   = (state_ff == S_ACC) ? lab_ff : grp_ff;
   assign ent       = valid_ff[ent_idx] ? ram_rdata : '0;

   lmsr_ram #(
      .WIDTH($bits(lmsr_entry_type)),
      .DEPTH(NUM_GROUPS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (lab_ff),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // updated entry for the write-back
   always_comb begin
      ram_we          = (state_ff == S_ACC) && acc_en_ff;
      ram_wdata.count = ent.count + CNT_W'(1);
      ram_wdata.sum   = ent.sum + SUM_W'(smp_ff);
      ram_wdata.sumsq = ent.sumsq + SQ_W'($unsigned(sqr_ff));
   end

   // shift-add multiplier step
   assign macc_nx = macc_ff + (mul_b_ff[0] ? mul_a_ff : '0);

   // restoring divider step, one quotient bit a cycle
   assign rem_sh   = {rem_ff, num_ff[NUM_W-1]};
   assign div_ge   = rem_sh >= {1'b0, den_ff};
   assign rem_full = div_ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
   assign rem_nx   = rem_full[DEN_W-1:0];
   assign quo_nx   = {quo_ff[NUM_W-2:0], div_ge};
   assign quo_sat  = (quo_nx > (NUM_W'(1) << SAT_SH)) ? (NUM_W'(1) << SAT_SH) : quo_nx;

   // signed floor of the mean, saturated to the field
   always_comb begin
      mean_v   = quo_nx + NUM_W'(rem_nx != '0);
      mean_neg = '0 - mean_v;
      if (neg_ff) begin
         if (mean_v > (NUM_W'(1) << (OUT_W - 1))) begin
            mean_res = {1'b1, {(OUT_W - 1){1'b0}}};
         end else begin
            mean_res = mean_neg[OUT_W-1:0];
         end
      end else begin
         if (quo_nx > ((NUM_W'(1) << (OUT_W - 1)) - NUM_W'(1))) begin
            mean_res = {1'b0, {(OUT_W - 1){1'b1}}};
         end else begin
            mean_res = quo_nx[OUT_W-1:0];
         end
      end
   end

   // square root step, two radicand bits a cycle
   assign srem_sh    = {srem_ff, rad_ff[RAD_W-1 -: 2]};
   assign srem_trial = {1'b0, root_ff, 2'b01};
   assign sqrt_ge    = srem_sh >= srem_trial;
   assign srem_full  = sqrt_ge ? (srem_sh - srem_trial) : srem_sh;
   assign root_nx    = {root_ff[ROOT_W-2:0], sqrt_ge};
   assign root_sat   = root_nx[ROOT_W-1] ? '1 : root_nx[OUT_W-1:0];

   assign step_done = (ctr_ff == CTR_W'(1));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      use_labels_in = use_labels_ff;
      valid_in      = valid_ff;
      highest_in    = highest_ff;
      batch_in      = batch_ff;
      ovf_in        = ovf_ff;
      lab_in        = lab_ff;
      smp_in        = smp_ff;
      sqr_in        = sqr_ff;
      last_in       = last_ff;
      acc_en_in     = acc_en_ff;
      grp_in        = grp_ff;
      cnt_in        = cnt_ff;
      sq_in         = sq_ff;
      neg_in        = neg_ff;
      smag_in       = smag_ff;
      nn_in         = nn_ff;
      prod_in       = prod_ff;
      mul_a_in      = mul_a_ff;
      mul_b_in      = mul_b_ff;
      macc_in       = macc_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      ctr_in        = ctr_ff;
      rad_in        = rad_ff;
      root_in       = root_ff;
      srem_in       = srem_ff;
      mean_in       = mean_ff;
      sd_in         = sd_ff;
      rms_in        = rms_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (csr_wr && (csr_paddr[CSR_ADDR_W-1:2] == REG_USE_LABELS)) begin
         use_labels_in = csr_pwdata[0];
      end

      case (state_ff)
         // take a sample; the store read is issued in the same cycle
         S_IDLE: begin
            if (req_xact) begin
               lab_in    = lab_sel;
               smp_in    = req_sample;
               sqr_in    = req_sample * req_sample;
               last_in   = req_last;
               acc_en_in = in_rng && !batch_full;
               if (in_rng && batch_full) begin
                  ovf_in = 1'b1;
               end
               state_in = S_ACC;
            end
         end
         // write back the updated entry
         S_ACC: begin
            if (acc_en_ff) begin
               valid_in[lab_ff] = 1'b1;
               batch_in         = batch_ff + BATCH_W'(1);
               if (lab_ff > highest_ff) begin
                  highest_in = lab_ff;
               end
            end
            if (last_ff) begin
               grp_in   = '0;
               state_in = S_EREAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EREAD: begin
            state_in = S_ELOAD;
         end
         // latch the group and start n*sumsq
         S_ELOAD: begin
            cnt_in   = ent.count;
            sq_in    = ent.sumsq;
            neg_in   = ent.sum[SUM_W-1];
            smag_in  = ent.sum[SUM_W-1] ? ('0 - ent.sum) : ent.sum;
            nn_in    = DEN_W'(ent.count) * DEN_W'(ent.count);
            mul_a_in = PROD_W'(ent.sumsq);
            mul_b_in = SUM_W'(ent.count);
            macc_in  = '0;
            ctr_in   = CTR_W'(CNT_W);
            if (ent.count == '0) begin
               mean_in      = '0;
               sd_in        = '0;
               rms_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = S_OUT;
            end else begin
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            macc_in  = macc_nx;
            mul_a_in = mul_a_ff << 1;
            mul_b_in = mul_b_ff >> 1;
            ctr_in   = ctr_ff - CTR_W'(1);
            if (step_done) begin
               prod_in  = macc_nx;
               mul_a_in = PROD_W'(smag_ff);
               mul_b_in = smag_ff;
               macc_in  = '0;
               ctr_in   = CTR_W'(SUM_W);
               state_in = S_MUL2;
            end
         end
         // sum^2, then the variance numerator clamped at zero
         S_MUL2: begin
            macc_in  = macc_nx;
            mul_a_in = mul_a_ff << 1;
            mul_b_in = mul_b_ff >> 1;
            ctr_in   = ctr_ff - CTR_W'(1);
            if (step_done) begin
               prod_in  = (prod_ff >= macc_nx) ? (prod_ff - macc_nx) : '0;
               num_in   = NUM_W'({smag_ff, {FRAC_W{1'b0}}});
               den_in   = DEN_W'(cnt_ff);
               rem_in   = '0;
               quo_in   = '0;
               ctr_in   = CTR_W'(NUM_W);
               state_in = S_DIVM;
            end
         end
         // |sum|*256 / n
         S_DIVM: begin
            num_in = num_ff << 1;
            rem_in = rem_nx;
            quo_in = quo_nx;
            ctr_in = ctr_ff - CTR_W'(1);
            if (step_done) begin
               mean_in  = mean_res;
               num_in   = {prod_ff, {SCALE_W{1'b0}}};
               den_in   = nn_ff;
               rem_in   = '0;
               quo_in   = '0;
               ctr_in   = CTR_W'(NUM_W);
               state_in = S_DIVS;
            end
         end
         // variance * 65536
         S_DIVS: begin
            num_in = num_ff << 1;
            rem_in = rem_nx;
            quo_in = quo_nx;
            ctr_in = ctr_ff - CTR_W'(1);
            if (step_done) begin
               rad_in   = quo_sat[RAD_W-1:0];
               root_in  = '0;
               srem_in  = '0;
               ctr_in   = CTR_W'(ROOT_W);
               state_in = S_SQRS;
            end
         end
         S_SQRS: begin
            rad_in  = rad_ff << 2;
            root_in = root_nx;
            srem_in = srem_full[SREM_W-1:0];
            ctr_in  = ctr_ff - CTR_W'(1);
            if (step_done) begin
               sd_in    = root_sat;
               num_in   = NUM_W'({sq_ff, {SCALE_W{1'b0}}});
               den_in   = DEN_W'(cnt_ff);
               rem_in   = '0;
               quo_in   = '0;
               ctr_in   = CTR_W'(NUM_W);
               state_in = S_DIVR;
            end
         end
         // mean square * 65536
         S_DIVR: begin
            num_in = num_ff << 1;
            rem_in = rem_nx;
            quo_in = quo_nx;
            ctr_in = ctr_ff - CTR_W'(1);
            if (step_done) begin
               rad_in   = quo_sat[RAD_W-1:0];
               root_in  = '0;
               srem_in  = '0;
               ctr_in   = CTR_W'(ROOT_W);
               state_in = S_SQRR;
            end
         end
         S_SQRR: begin
            rad_in  = rad_ff << 2;
            root_in = root_nx;
            srem_in = srem_full[SREM_W-1:0];
            ctr_in  = ctr_ff - CTR_W'(1);
            if (step_done) begin
               rms_in       = root_sat;
               rsp_valid_in = 1'b1;
               state_in     = S_OUT;
            end
         end
         // hold the result until taken; clear the batch after the last group
         S_OUT: begin
            if (rsp_xact) begin
               rsp_valid_in = 1'b0;
               if (grp_ff == highest_ff) begin
                  valid_in   = '0;
                  highest_in = '0;
                  batch_in   = '0;
                  ovf_in     = 1'b0;
                  state_in   = S_IDLE;
               end else begin
                  grp_in   = grp_ff + GRP_W'(1);
                  state_in = S_EREAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         use_labels_ff <= 1'b1;
         valid_ff      <= '0;
         highest_ff    <= '0;
         batch_ff      <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         use_labels_ff <= use_labels_in;
         valid_ff      <= valid_in;
         highest_ff    <= highest_in;
         batch_ff      <= batch_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      lab_ff    <= lab_in;
      smp_ff    <= smp_in;
      sqr_ff    <= sqr_in;
      last_ff   <= last_in;
      acc_en_ff <= acc_en_in;
      grp_ff    <= grp_in;
      cnt_ff    <= cnt_in;
      sq_ff     <= sq_in;
      neg_ff    <= neg_in;
      smag_ff   <= smag_in;
      nn_ff     <= nn_in;
      prod_ff   <= prod_in;
      mul_a_ff  <= mul_a_in;
      mul_b_ff  <= mul_b_in;
      macc_ff   <= macc_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      ctr_ff    <= ctr_in;
      rad_ff    <= rad_in;
      root_ff   <= root_in;
      srem_ff   <= srem_in;
      mean_ff   <= mean_in;
      sd_ff     <= sd_in;
      rms_ff    <= rms_in;
   end

   // result outputs
   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_group       = grp_ff;
   assign rsp_count       = cnt_ff;
   assign rsp_mean_value  = mean_ff;
   assign rsp_std_dev     = sd_ff;
   assign rsp_rms_value   = rms_ff;
   assign rsp_overflow    = ovf_ff;
   assign rsp_last_of_run = (grp_ff == highest_ff);

   // checks
   `LMSR_ASSERT(a_no_take_while_report, rsp_valid_ff |-> !req_ready, "sample taken while reporting")
   `LMSR_ASSERT(a_batch_bound, batch_ff <= BATCH_W'(MAX_SAMPLES), "batch size past limit")
   `LMSR_ASSERT(a_empty_zero, (rsp_valid_ff && (cnt_ff == '0)) |-> ((mean_ff == '0) && (sd_ff == '0) && (rms_ff == '0)), "empty group with nonzero values")
   `LMSR_ASSERT_NEXT(a_batch_clear, rsp_xact && rsp_last_of_run, (valid_ff == '0) && (batch_ff == '0) && (highest_ff == '0) && !ovf_ff, "store not cleared after batch")

endmodule

/* test/tb_labeled_mean_sigma_rms.sv */
// Testbench for labeled_mean_sigma_rms: a scoreboard class predicts per-group
// statistics per batch, and plain tasks drive samples and register writes.
// Depends on lmsr_pkg and the labeled_mean_sigma_rms RTL.
`timescale 1ns / 1ps

module tb_labeled_mean_sigma_rms;
   import lmsr_pkg::*;

   // one expected result transaction
   typedef struct {
      logic [GRP_W-1:0]        group;
      logic [CNT_W-1:0]        count;
      logic signed [OUT_W-1:0] mean_value;
      logic [OUT_W-1:0]        std_dev;
      logic [OUT_W-1:0]        rms_value;
      logic                    overflow;
      logic                    last_of_run;
   } group_stats_type;

   // predicts group statistics and checks the result stream
   class group_stats_board;
      longint unsigned   cnt [NUM_GROUPS];
      longint            sum [NUM_GROUPS];
      longint unsigned   sumsq [NUM_GROUPS];
      int unsigned       top_label;
      longint unsigned   batch_len;
      bit                ovf_seen;
      bit                labels_on;
      group_stats_type   pending_stats[$];
      int unsigned       errors;

      function new();
         clear_batch();
         labels_on = 1'b1;
         errors    = 0;
      endfunction

      function void clear_batch();
         for (int g = 0; g < NUM_GROUPS; g++) begin
            cnt[g]   = 0;
            sum[g]   = 0;
            sumsq[g] = 0;
         end
         top_label = 0;
         batch_len = 0;
         ovf_seen  = 1'b0;
      endfunction

      // floor(x * 2^16 / den), saturated to 2^48
      function longint unsigned scaled_quot(bit [127:0] x, bit [127:0] den);
         bit [127:0] q;
         if ((x >> 112) != 0) return 64'd1 << SAT_SH;
         q = (x << SCALE_W) / den;
         if (q > (128'd1 << SAT_SH)) return 64'd1 << SAT_SH;
         return q[63:0];
      endfunction

      // floor square root, saturated to the output width
      function longint unsigned root_sat(longint unsigned x);
         longint unsigned res, bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > x) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (x >= res + bitv) begin
               x   = x - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return (res > 64'hFFFFFF) ? 64'hFFFFFF : res;
      endfunction

      // accepted sample transaction: accumulate, and on last emit expectations
      function void note_sample(logic signed [SAMPLE_BITS-1:0] smp,
                                logic [GRP_W-1:0] lbl, logic lst);
         int unsigned      g;
         longint           sv, num, q;
         longint unsigned  mag, n;
         bit [127:0]       a, b, d;
         group_stats_type  r;
         g  = labels_on ? lbl : 0;
         sv = smp;
         if (g < NUM_GROUPS) begin
            if (batch_len >= MAX_SAMPLES) begin
               ovf_seen = 1'b1;
            end else begin
               mag = (sv < 0) ? -sv : sv;
               batch_len++;
               cnt[g]++;
               sum[g]   = sum[g] + sv;
               sumsq[g] = (sumsq[g] + mag * mag) & ((64'd1 << SQ_W) - 1);
               if (g > top_label) top_label = g;
            end
         end
         if (!lst) return;
         for (int k = 0; k <= top_label; k++) begin
            n = cnt[k];
            r.group       = GRP_W'(k);
            r.count       = CNT_W'(n);
            r.mean_value  = '0;
            r.std_dev     = '0;
            r.rms_value   = '0;
            r.overflow    = ovf_seen;
            r.last_of_run = (k == top_label);
            if (n != 0) begin
               num = sum[k] * 256;
               q   = num / longint'(n);
               if ((num % longint'(n)) != 0 && num < 0) q = q - 1;
               if (q > 8388607) q = 8388607;
               if (q < -8388608) q = -8388608;
               r.mean_value = OUT_W'(q);
               mag = (sum[k] < 0) ? -sum[k] : sum[k];
               a = 128'(n) * 128'(sumsq[k]);
               b = 128'(mag) * 128'(mag);
               d = (a < b) ? 128'd0 : a - b;
               r.std_dev   = OUT_W'(root_sat(scaled_quot(d, 128'(n) * 128'(n))));
               r.rms_value = OUT_W'(root_sat(scaled_quot(128'(sumsq[k]), 128'(n))));
            end
            pending_stats.push_back(r);
         end
         clear_batch();
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      // accepted result transaction against the oldest expectation
      task check_result(group_stats_type got);
         group_stats_type e;
         if (pending_stats.size() == 0) begin
            report("unexpected result, group", got.group, 0);
            return;
         end
         e = pending_stats.pop_front();
         if (got.group !== e.group) report("group", got.group, e.group);
         if (got.count !== e.count) report("count", got.count, e.count);
         if (got.mean_value !== e.mean_value)
            report("mean_value", got.mean_value, e.mean_value);
         if (got.std_dev !== e.std_dev) report("std_dev", got.std_dev, e.std_dev);
         if (got.rms_value !== e.rms_value)
            report("rms_value", got.rms_value, e.rms_value);
         if (got.overflow !== e.overflow) report("overflow", got.overflow, e.overflow);
         if (got.last_of_run !== e.last_of_run)
            report("last_of_run", got.last_of_run, e.last_of_run);
      endtask
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic [GRP_W-1:0]              req_label;
   logic                          req_last;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [GRP_W-1:0]              rsp_group;
   logic [CNT_W-1:0]              rsp_count;
   logic signed [OUT_W-1:0]       rsp_mean_value;
   logic [OUT_W-1:0]              rsp_std_dev;
   logic [OUT_W-1:0]              rsp_rms_value;
   logic                          rsp_overflow;
   logic                          rsp_last_of_run;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [CSR_ADDR_W-1:0]         csr_paddr;
   logic [CSR_DATA_W-1:0]         csr_pwdata;
   logic [CSR_DATA_W-1:0]         csr_prdata;
   logic                          csr_pready;

   group_stats_board stats_board;
   bit               idle_on;
   int               hold_request;
   int               items_sent;

   labeled_mean_sigma_rms DUT (.*);

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // sample transaction; valid stays high into the next call unless it idles
   task send_sample(logic signed [SAMPLE_BITS-1:0] smp, logic [GRP_W-1:0] lbl,
                    logic lst);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= smp;
      req_label  <= lbl;
      req_last   <= lst;
      do @(posedge clock); while (!req_ready);
      stats_board.note_sample(smp, lbl, lst);
      items_sent++;
   endtask

   // register write: setup then access cycle
   task write_use_labels(logic val);
      @(posedge clock);
      req_valid   <= 1'b0;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * REG_USE_LABELS);
      csr_pwdata  <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      stats_board.labels_on = val;
   endtask

   // every expected result in, then a short settle
   task wait_results_done();
      @(posedge clock);
      req_valid <= 1'b0;
      while (stats_board.pending_stats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0:       return -16'sd32768;
         1:       return 16'sd32767;
         2:       return SAMPLE_BITS'($urandom_range(0, 15)) - 16'sd8;
         default: return SAMPLE_BITS'($urandom());
      endcase
   endfunction

   // random batch; labels mostly small to keep reporting short
   task random_batch();
      int len, top;
      len = $urandom_range(1, 12);
      top = ($urandom_range(0, 5) == 0) ? 63 : $urandom_range(0, 7);
      for (int i = 0; i < len; i++)
         send_sample(pick_sample(), GRP_W'($urandom_range(0, top)), i == len - 1);
   endtask

   // result side: sample, check, then random stalls or a long hold
   initial begin
      int stall;
      group_stats_type got;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.group       = rsp_group;
            got.count       = rsp_count;
            got.mean_value  = rsp_mean_value;
            got.std_dev     = rsp_std_dev;
            got.rms_value   = rsp_rms_value;
            got.overflow    = rsp_overflow;
            got.last_of_run = rsp_last_of_run;
            stats_board.check_result(got);
         end
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (!reset && idle_on && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 19);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !reset;
         end
      end
   end

   // watchdog
   initial begin
      #(8 * 40000000);
      $display("tb_labeled_mean_sigma_rms NOT OK");
      $finish;
   end

   // stimulus
   initial begin
      stats_board  = new();
      idle_on      = 1'b1;
      hold_request = 0;
      items_sent   = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_sample   = '0;
      req_label    = '0;
      req_last     = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, empty groups in between, single-sample batches
      send_sample(-16'sd32768, 6'd0, 1'b0);
      send_sample(-16'sd32768, 6'd0, 1'b0);
      send_sample(16'sd32767, 6'd5, 1'b0);
      send_sample(-16'sd1, 6'd5, 1'b0);
      send_sample(16'sd3, 6'd5, 1'b1);
      send_sample(16'sd7, 6'd0, 1'b1);
      send_sample(-16'sd5, 6'd63, 1'b0);
      send_sample(16'sd32767, 6'd63, 1'b0);
      send_sample(16'sd0, 6'd42, 1'b0);
      send_sample(16'sd1, 6'd21, 1'b1);
      send_sample(-16'sd32768, 6'd3, 1'b1);
      send_sample(16'sd32767, 6'd1, 1'b0);
      send_sample(16'sd32767, 6'd1, 1'b1);
      wait_results_done();

      // labels ignored: all samples land in group zero
      write_use_labels(1'b0);
      send_sample(-16'sd9, 6'd63, 1'b0);
      send_sample(16'sd11, 6'd17, 1'b1);
      while (items_sent < 120) random_batch();
      wait_results_done();

      // labels back on; long result hold while samples keep coming
      write_use_labels(1'b1);
      hold_request = 600;
      while (items_sent < 200) random_batch();
      wait_results_done();
      while (items_sent < 280) random_batch();

      // last part with no idling
      idle_on = 1'b0;
      while (items_sent < 320) random_batch();
      wait_results_done();
      repeat (500) @(posedge clock);

      if (stats_board.errors == 0 && stats_board.pending_stats.size() == 0) begin
         $display("tb_labeled_mean_sigma_rms OK");
      end else begin
         $display("tb_labeled_mean_sigma_rms NOT OK");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/lmsr_pkg.sv
rtl/lmsr_ram.sv
rtl/labeled_mean_sigma_rms.sv
test/tb_labeled_mean_sigma_rms.sv
